@@ rtl/zoomed_sprite_blitter_core_assert.svh @@
// Assertion macros for the zoomed sprite blitter.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef ZOOMED_SPRITE_BLITTER_CORE_ASSERT_SVH
`define ZOOMED_SPRITE_BLITTER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ZSB_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ZSB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/zsb_pkg.sv @@
// Shared types and constants of the zoomed sprite blitter.
// No dependencies; imported by every module of the block but zsb_fifo.
`default_nettype none

package zsb_pkg;

  localparam int ZOOM_W     = 6;
  localparam int ZOOM_MAX   = (1 << ZOOM_W) - 1;
  localparam int DEN_W      = ZOOM_W + 1;
  localparam int COORD_W    = 12;
  localparam int SCREEN_W   = 13;
  localparam int PIX_ADDR_W = 12;
  localparam int INDEX_W    = 8;
  localparam int CADDR_W    = 8;
  localparam int CVAL_W     = 32;
  localparam int SRC_W      = 8;
  localparam int STEP_Q_W   = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int CMD_DEPTH  = 2;
  localparam int OUT_DEPTH  = 4;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_ZOOM_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZOOM_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_H     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_V     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPARENT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 3'd6;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_COLOUR = 2'd1,
    KIND_RENDER = 2'd2
  } kind_e;

  typedef struct packed {
    logic [ZOOM_W-1:0]  zoom_x;
    logic [ZOOM_W-1:0]  zoom_y;
    logic               mirror_horizontal;
    logic               mirror_vertical;
    logic               transparent_mode;
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
  } cfg_t;

  // One classified command travelling from the front to the back.
  typedef struct packed {
    kind_e                 kind;
    logic [PIX_ADDR_W-1:0] pixel_address;
    logic [INDEX_W-1:0]    pixel_index;
    logic [CADDR_W-1:0]    colour_address;
    logic [CVAL_W-1:0]     colour_value;
    logic [SRC_W-1:0]      src_row;
    logic [STEP_Q_W-1:0]   step_q;
    logic [DEN_W-1:0]      step_r;
    logic [SCREEN_W-1:0]   screen_y;
  } cmd_t;

  typedef struct packed {
    logic [SCREEN_W-1:0] screen_x;
    logic [SCREEN_W-1:0] screen_y;
    logic [CVAL_W-1:0]   colour;
    logic                write_enable;
    logic                last;
  } pix_t;

endpackage

`default_nettype wire

@@ rtl/zsb_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on zsb_pkg for the divisor width.
`default_nettype none

module zsb_div #(
  parameter int NUM_W = 12
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [NUM_W-1:0]          numer_i,
  input  logic [zsb_pkg::DEN_W-1:0] denom_i,
  output logic                      done_o,
  output logic [NUM_W-1:0]          quot_o,
  output logic [zsb_pkg::DEN_W-1:0] rem_o
);
  import zsb_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   shifted;
  logic             ge;

  assign done_o = busy_q && (cnt_q == '0);
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

  // One shift-and-subtract step per cycle.
  always_comb begin
    shifted = {rem_q, quo_q[NUM_W-1]};
    ge      = shifted >= {1'b0, den_q};
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
      quo_d  = numer_i;
      rem_d  = '0;
      den_d  = denom_i;
    end else if (busy_q && (cnt_q != '0)) begin
      cnt_d = cnt_q - CNT_W'(1);
      quo_d = {quo_q[NUM_W-2:0], ge};
      rem_d = ge ? DEN_W'(shifted - {1'b0, den_q}) : DEN_W'(shifted);
    end else if (done_o) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

endmodule

`default_nettype wire

@@ rtl/zsb_fifo.sv @@
// Small register FIFO with a fill count.
// Depends on nothing but its parameters.
`default_nettype none

module zsb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           data_o,
  output logic                       empty_o,
  output logic                       full_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign count_o = cnt_q;
  assign data_o  = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and count update.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/zsb_front.sv @@
// Front end: accepts input items, drops those without effect and works out
// the row source and column step of render commands. Uses zsb_pkg, zsb_div.
`default_nettype none

module zsb_front #(
  parameter int SPRITE_SIZE = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  zsb_pkg::cfg_t                  cfg_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     kind_i,
  input  logic [zsb_pkg::PIX_ADDR_W-1:0] pixel_address_i,
  input  logic [zsb_pkg::INDEX_W-1:0]    pixel_index_i,
  input  logic [zsb_pkg::CADDR_W-1:0]    colour_address_i,
  input  logic [zsb_pkg::CVAL_W-1:0]     colour_value_i,
  input  logic [zsb_pkg::ZOOM_W-1:0]     dest_row_i,
  input  logic                           q_full_i,
  output logic                           q_push_o,
  output zsb_pkg::cmd_t                  q_data_o
);
  import zsb_pkg::*;

  localparam int NUM_W = $clog2(ZOOM_MAX * SPRITE_SIZE + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIVX = 2'd1;
  localparam logic [1:0] ST_DIVY = 2'd2;
  localparam logic [1:0] ST_PUSH = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [ZOOM_W-1:0]   row_q, row_d;
  logic [STEP_Q_W-1:0] stepq_q, stepq_d;
  logic [DEN_W-1:0]    stepr_q, stepr_d;
  logic [SRC_W-1:0]    srow_q, srow_d;

  logic              accept;
  logic [ZOOM_W-1:0] prow;
  logic              div_start, div_done;
  logic [NUM_W-1:0]  div_numer, div_quot;
  logic [DEN_W-1:0]  div_denom, div_rem;

  assign in_ready_o = (state_q == ST_IDLE) && !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign prow       = cfg_i.mirror_vertical ? (cfg_i.zoom_y - row_q) : row_q;

  zsb_div #(
    .NUM_W(NUM_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .numer_i(div_numer),
    .denom_i(div_denom),
    .done_o (div_done),
    .quot_o (div_quot),
    .rem_o  (div_rem)
  );

  // Sequencer: classify, then divide the sprite size by the width and the
  // scaled row by the height.
  always_comb begin
    state_d   = state_q;
    row_d     = row_q;
    stepq_d   = stepq_q;
    stepr_d   = stepr_q;
    srow_d    = srow_q;
    div_start = 1'b0;
    div_numer = NUM_W'(SPRITE_SIZE);
    div_denom = DEN_W'(cfg_i.zoom_x) + DEN_W'(1);
    q_push_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (kind_e'(kind_i))
            KIND_PIXEL, KIND_COLOUR: begin
              q_push_o = 1'b1;
            end
            KIND_RENDER: begin
              if (dest_row_i <= cfg_i.zoom_y) begin
                row_d     = dest_row_i;
                div_start = 1'b1;
                state_d   = ST_DIVX;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DIVX: begin
        div_numer = NUM_W'(NUM_W'(prow) * NUM_W'(SPRITE_SIZE));
        div_denom = DEN_W'(cfg_i.zoom_y) + DEN_W'(1);
        if (div_done) begin
          stepq_d   = STEP_Q_W'(div_quot);
          stepr_d   = div_rem;
          div_start = 1'b1;
          state_d   = ST_DIVY;
        end
      end
      ST_DIVY: begin
        if (div_done) begin
          srow_d  = SRC_W'(div_quot);
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!q_full_i) begin
          q_push_o = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Command word: load fields pass straight through, render fields come
  // from the divider results, the screen row from origin_y and the destination row.
  always_comb begin
    q_data_o.kind           = (state_q == ST_PUSH) ? KIND_RENDER : kind_e'(kind_i);
    q_data_o.pixel_address  = pixel_address_i;
    q_data_o.pixel_index    = pixel_index_i;
    q_data_o.colour_address = colour_address_i;
    q_data_o.colour_value   = colour_value_i;
    q_data_o.src_row        = srow_q;
    q_data_o.step_q         = stepq_q;
    q_data_o.step_r         = stepr_q;
    q_data_o.screen_y       = SCREEN_W'(cfg_i.origin_y) + SCREEN_W'(row_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q   <= row_d;
    stepq_q <= stepq_d;
    stepr_q <= stepr_d;
    srow_q  <= srow_d;
  end

endmodule

`default_nettype wire

@@ rtl/zsb_back.sv @@
// Back end: owns the sprite and colour memories, performs loads and walks
// render rows one pixel per cycle while the output buffer has room. Uses zsb_pkg, zsb_fifo.
`default_nettype none

module zsb_back #(
  parameter int SPRITE_SIZE    = 64,
  parameter int COLOUR_ENTRIES = 256,
  parameter int COLOUR_WIDTH   = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  zsb_pkg::cfg_t cfg_i,
  input  logic          cmd_valid_i,
  input  zsb_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output zsb_pkg::pix_t pix_o
);
  import zsb_pkg::*;

  localparam int SC_W      = $clog2(SPRITE_SIZE);
  localparam int PIX_CNT   = SPRITE_SIZE * SPRITE_SIZE;
  localparam int PIX_AW    = $clog2(PIX_CNT);
  localparam int CA_W      = $clog2(COLOUR_ENTRIES);
  localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);
  localparam logic [STEP_Q_W-1:0] SIZE_V = STEP_Q_W'(SPRITE_SIZE);

  // Memories, no reset: contents are defined only once written.
  logic [INDEX_W-1:0]      spr_mem [PIX_CNT];
  logic [COLOUR_WIDTH-1:0] col_mem [COLOUR_ENTRIES];

  // Row walker.
  logic                busy_q, busy_d;
  logic [ZOOM_W-1:0]   col_q, col_d;
  logic [SC_W-1:0]     qx_q, qx_d;
  logic [DEN_W-1:0]    rx_q, rx_d;
  logic [SC_W-1:0]     srow_q, srow_d;
  logic [STEP_Q_W-1:0] stepq_q, stepq_d;
  logic [DEN_W-1:0]    stepr_q, stepr_d;
  logic [SCREEN_W-1:0] sy_q, sy_d;

  // Read pipeline.
  logic                    s1_v_q, s2_v_q;
  logic [INDEX_W-1:0]      spr_rd_q;
  logic [SCREEN_W-1:0]     s1_x_q, s1_y_q, s2_x_q, s2_y_q;
  logic                    s1_last_q, s2_last_q;
  logic [COLOUR_WIDTH-1:0] col_rd_q;
  logic                    s2_zero_q, s2_ok_q;

  logic                cmd_pop, spr_we, col_we, issue, row_end;
  logic [DEN_W-1:0]    dz;
  logic [DEN_W:0]      sum_r, diff_r;
  logic [PIX_AW-1:0]   rd_addr;
  logic [OCNT_W:0]     pending;
  logic [OCNT_W-1:0]   ofifo_cnt;
  logic                ofifo_empty, ofifo_full;
  logic                pix_we;
  pix_t                pix_new;

  assign dz        = DEN_W'(cfg_i.zoom_x) + DEN_W'(1);
  assign cmd_pop   = !busy_q && cmd_valid_i;
  assign cmd_pop_o = cmd_pop;
  assign spr_we    = cmd_pop && (cmd_i.kind == KIND_PIXEL)
                     && (32'(cmd_i.pixel_address) < 32'(PIX_CNT));
  assign col_we    = cmd_pop && (cmd_i.kind == KIND_COLOUR)
                     && (32'(cmd_i.colour_address) < 32'(COLOUR_ENTRIES));

  // Issue only when the output buffer has room for everything in flight.
  assign pending = (OCNT_W + 1)'(ofifo_cnt) + (OCNT_W + 1)'(s1_v_q)
                   + (OCNT_W + 1)'(s2_v_q);
  assign issue   = busy_q && (pending < (OCNT_W + 1)'(OUT_DEPTH));
  assign row_end = (col_q == cfg_i.zoom_x);
  assign rd_addr = PIX_AW'(PIX_AW'(srow_q) * PIX_AW'(SPRITE_SIZE)) + PIX_AW'(qx_q);
  assign sum_r   = {1'b0, rx_q} + {1'b0, stepr_q};
  assign diff_r  = {1'b0, rx_q} - {1'b0, stepr_q};

  // Row start and incremental source column: quotient and remainder of
  // pos * size / (zoom_x + 1) are stepped by size / (zoom_x + 1).
  always_comb begin
    busy_d  = busy_q;
    col_d   = col_q;
    qx_d    = qx_q;
    rx_d    = rx_q;
    srow_d  = srow_q;
    stepq_d = stepq_q;
    stepr_d = stepr_q;
    sy_d    = sy_q;
    if (cmd_pop && (cmd_i.kind == KIND_RENDER)) begin
      busy_d  = 1'b1;
      col_d   = '0;
      srow_d  = SC_W'(cmd_i.src_row);
      stepq_d = cmd_i.step_q;
      stepr_d = cmd_i.step_r;
      sy_d    = cmd_i.screen_y;
      if (!cfg_i.mirror_horizontal) begin
        qx_d = '0;
        rx_d = '0;
      end else if (cmd_i.step_r == '0) begin
        qx_d = SC_W'(SIZE_V - cmd_i.step_q);
        rx_d = '0;
      end else begin
        qx_d = SC_W'(SIZE_V - cmd_i.step_q - STEP_Q_W'(1));
        rx_d = dz - cmd_i.step_r;
      end
    end else if (issue) begin
      col_d = col_q + ZOOM_W'(1);
      if (row_end) begin
        busy_d = 1'b0;
      end
      if (!cfg_i.mirror_horizontal) begin
        if (sum_r >= {1'b0, dz}) begin
          rx_d = DEN_W'(sum_r - {1'b0, dz});
          qx_d = qx_q + SC_W'(stepq_q) + SC_W'(1);
        end else begin
          rx_d = DEN_W'(sum_r);
          qx_d = qx_q + SC_W'(stepq_q);
        end
      end else begin
        if (diff_r[DEN_W]) begin
          rx_d = DEN_W'(diff_r + {1'b0, dz});
          qx_d = qx_q - SC_W'(stepq_q) - SC_W'(1);
        end else begin
          rx_d = DEN_W'(diff_r);
          qx_d = qx_q - SC_W'(stepq_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q   <= col_d;
    qx_q    <= qx_d;
    rx_q    <= rx_d;
    srow_q  <= srow_d;
    stepq_q <= stepq_d;
    stepr_q <= stepr_d;
    sy_q    <= sy_d;
  end

  // Sprite memory: load port and registered read for the row walker.
  always_ff @(posedge clk_i) begin
    if (spr_we) begin
      spr_mem[PIX_AW'(cmd_i.pixel_address)] <= cmd_i.pixel_index;
    end
    if (issue) begin
      spr_rd_q <= spr_mem[rd_addr];
    end
  end

  // Colour memory: load port and registered lookup of the sprite index.
  always_ff @(posedge clk_i) begin
    if (col_we) begin
      col_mem[CA_W'(cmd_i.colour_address)] <= COLOUR_WIDTH'(cmd_i.colour_value);
    end
    if (s1_v_q) begin
      col_rd_q <= col_mem[CA_W'(spr_rd_q)];
    end
  end

  // Pixel coordinates travel alongside the memory reads.
  always_ff @(posedge clk_i) begin
    s1_x_q    <= SCREEN_W'(cfg_i.origin_x) + SCREEN_W'(col_q);
    s1_y_q    <= sy_q;
    s1_last_q <= row_end;
    s2_x_q    <= s1_x_q;
    s2_y_q    <= s1_y_q;
    s2_last_q <= s1_last_q;
    s2_zero_q <= (spr_rd_q == '0);
    s2_ok_q   <= (32'(spr_rd_q) < 32'(COLOUR_ENTRIES));
  end

  // Transparency and colour forming.
  always_comb begin
    pix_we               = !(cfg_i.transparent_mode && s2_zero_q);
    pix_new.screen_x     = s2_x_q;
    pix_new.screen_y     = s2_y_q;
    pix_new.colour       = (pix_we && s2_ok_q) ? CVAL_W'(col_rd_q) : '0;
    pix_new.write_enable = pix_we;
    pix_new.last         = s2_last_q;
  end

  zsb_fifo #(
    .WIDTH($bits(pix_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (s2_v_q),
    .data_i (pix_new),
    .pop_i  (out_ready_i),
    .data_o (pix_o),
    .empty_o(ofifo_empty),
    .full_o (ofifo_full),
    .count_o(ofifo_cnt)
  );

  assign out_valid_o = !ofifo_empty && (ofifo_full || !ofifo_full);

endmodule

`default_nettype wire

@@ rtl/zoomed_sprite_blitter_core.sv @@
// Top level of the zoomed sprite blitter: configuration registers, front
// end, command queue and back end. Uses zsb_pkg, zsb_front, zsb_fifo, zsb_back.
//
//   Channel   Direction  Transfer on               Carries
//   in        input      in_valid_i & in_ready_o   one load or render command
//   out       output     out_valid_o & out_ready_i one pixel of a rendered row
//   cfg       input      cfg_we_i                  one register write
//
// A load is queued in the cycle it is accepted and written when the back pops it.
// A render row emits zoom_x + 1 pixels at one per cycle while the output buffer
// has room, paced by the sprite memory read port; the front computes the column
// step and then the source row in its serial divider, overlapped with the previous row at the back.
// Reset clears all control state; both memories hold garbage until loaded.
// A stalled output stops pixel issue once the four-entry output buffer is
// committed; the front keeps taking items until its two-entry queue fills.
`default_nettype none

module zoomed_sprite_blitter_core #(
  parameter int SPRITE_SIZE    = 64,
  parameter int COLOUR_ENTRIES = 256,
  parameter int COLOUR_WIDTH   = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [zsb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [zsb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     kind_i,
  input  logic [zsb_pkg::PIX_ADDR_W-1:0] pixel_address_i,
  input  logic [zsb_pkg::INDEX_W-1:0]    pixel_index_i,
  input  logic [zsb_pkg::CADDR_W-1:0]    colour_address_i,
  input  logic [zsb_pkg::CVAL_W-1:0]     colour_value_i,
  input  logic [zsb_pkg::ZOOM_W-1:0]     dest_row_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [zsb_pkg::SCREEN_W-1:0]   screen_x_o,
  output logic [zsb_pkg::SCREEN_W-1:0]   screen_y_o,
  output logic [zsb_pkg::CVAL_W-1:0]     colour_o,
  output logic                           write_enable_o,
  output logic                           last_o
);
  import zsb_pkg::*;

  `include "zoomed_sprite_blitter_core_assert.svh"

  localparam int QCNT_W = $clog2(CMD_DEPTH + 1);

  cfg_t              cfg_q, cfg_d;
  logic              q_push, q_pop, q_empty, q_full;
  cmd_t              q_wdata, q_rdata;
  logic [QCNT_W-1:0] q_count;
  pix_t              pix;

  // Configuration register writes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ZOOM_X:      cfg_d.zoom_x            = ZOOM_W'(cfg_data_i);
        CFG_ZOOM_Y:      cfg_d.zoom_y            = ZOOM_W'(cfg_data_i);
        CFG_MIRROR_H:    cfg_d.mirror_horizontal = cfg_data_i[0];
        CFG_MIRROR_V:    cfg_d.mirror_vertical   = cfg_data_i[0];
        CFG_TRANSPARENT: cfg_d.transparent_mode  = cfg_data_i[0];
        CFG_ORIGIN_X:    cfg_d.origin_x          = COORD_W'(cfg_data_i);
        CFG_ORIGIN_Y:    cfg_d.origin_y          = COORD_W'(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zoom_x            <= ZOOM_W'(ZOOM_MAX);
      cfg_q.zoom_y            <= ZOOM_W'(ZOOM_MAX);
      cfg_q.mirror_horizontal <= 1'b0;
      cfg_q.mirror_vertical   <= 1'b0;
      cfg_q.transparent_mode  <= 1'b1;
      cfg_q.origin_x          <= '0;
      cfg_q.origin_y          <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  zsb_front #(
    .SPRITE_SIZE(SPRITE_SIZE)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .pixel_address_i (pixel_address_i),
    .pixel_index_i   (pixel_index_i),
    .colour_address_i(colour_address_i),
    .colour_value_i  (colour_value_i),
    .dest_row_i      (dest_row_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_data_o        (q_wdata)
  );

  // Command queue between front and back.
  zsb_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .empty_o(q_empty),
    .full_o (q_full),
    .count_o(q_count)
  );

  zsb_back #(
    .SPRITE_SIZE   (SPRITE_SIZE),
    .COLOUR_ENTRIES(COLOUR_ENTRIES),
    .COLOUR_WIDTH  (COLOUR_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_valid_i(!q_empty),
    .cmd_i      (q_rdata),
    .cmd_pop_o  (q_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .pix_o      (pix)
  );

  assign screen_x_o     = pix.screen_x;
  assign screen_y_o     = pix.screen_y;
  assign colour_o       = pix.colour;
  assign write_enable_o = pix.write_enable;
  assign last_o         = pix.last;

  // The front never pushes into a full queue, the back never pops an empty one,
  // the full flag matches the count, and a full queue with no pop keeps the input stalled.
  `ZSB_ASSERT_HOLDS(a_no_push_when_full, q_push, !q_full, "command pushed into full queue")
  `ZSB_ASSERT_HOLDS(a_no_pop_when_empty, q_pop, !q_empty, "command popped from empty queue")
  `ZSB_ASSERT_HOLDS(a_count_matches_flags, q_full, q_count == QCNT_W'(CMD_DEPTH),
                    "queue full flag disagrees with its count")
  `ZSB_ASSERT_NEXT(a_full_blocks_input, q_full && !q_pop, !in_ready_o,
                   "input accepted while the command queue stayed full")

endmodule

`default_nettype wire

@@ verif/tb_zoomed_sprite_blitter_core.sv @@
// Self-checking testbench for zoomed_sprite_blitter_core: loads the sprite and colour
// stores, renders zoomed rows and checks every pixel against a local zoom-blit predictor.
// Depends on zsb_pkg and the zoomed_sprite_blitter_core RTL only.
`timescale 1ns / 1ps

module tb_zoomed_sprite_blitter_core;
  import zsb_pkg::*;

  localparam int SPRITE_SIZE    = 64;
  localparam int PIXEL_COUNT    = SPRITE_SIZE * SPRITE_SIZE;
  localparam int COLOUR_ENTRIES = 256;
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int SETTLE_CYCLES  = 200;
  localparam int HOLD_CYCLES    = 300;
  localparam int ITEMS_PER_SET  = 18;
  localparam int MAX_REPORTS    = 10;

  // Codes the package leaves unnamed: the unused kind and the spare register index.
  localparam logic [1:0]           KIND_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 3'd7;

  // One input item, one field per port.
  typedef struct packed {
    logic [1:0]            kind;
    logic [PIX_ADDR_W-1:0] pixel_address;
    logic [INDEX_W-1:0]    pixel_index;
    logic [CADDR_W-1:0]    colour_address;
    logic [CVAL_W-1:0]     colour_value;
    logic [ZOOM_W-1:0]     dest_row;
  } item_t;

  // One row of the directed table; px is used only where typed is set.
  typedef struct {
    int    setting;
    item_t it;
    bit    typed;
    pix_t  px;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [1:0]            kind_i = '0;
  logic [PIX_ADDR_W-1:0] pixel_address_i = '0;
  logic [INDEX_W-1:0]    pixel_index_i = '0;
  logic [CADDR_W-1:0]    colour_address_i = '0;
  logic [CVAL_W-1:0]     colour_value_i = '0;
  logic [ZOOM_W-1:0]     dest_row_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [SCREEN_W-1:0]   screen_x_o;
  logic [SCREEN_W-1:0]   screen_y_o;
  logic [CVAL_W-1:0]     colour_o;
  logic                  write_enable_o;
  logic                  last_o;

  // Predictor state: both stores, which entries hold data, and the live settings.
  logic [INDEX_W-1:0] sprite_mem [PIXEL_COUNT];
  logic [CVAL_W-1:0]  colour_mem [COLOUR_ENTRIES];
  bit                 sprite_set [PIXEL_COUNT];
  bit                 colour_set [COLOUR_ENTRIES];
  cfg_t               blit_cfg;

  pix_t pixels_due [$];
  int   mismatch_count = 0;
  int   cycle_count = 0;
  int   send_idle_pct = 22;
  int   recv_idle_pct = 65;
  bit   hold_req = 1'b0;
  int   hold_left = 0;

  // Directed settings: smallest zoom at the far screen corner, opaque mode at the
  // origin, full size mirrored both ways, full width two rows high at the corner.
  cfg_t dir_settings [4] = '{
    '{6'd0,  6'd0,  1'b0, 1'b0, 1'b1, 12'd4095, 12'd4095},
    '{6'd0,  6'd0,  1'b0, 1'b0, 1'b0, 12'd0,    12'd0},
    '{6'd63, 6'd63, 1'b1, 1'b1, 1'b1, 12'd0,    12'd0},
    '{6'd63, 6'd1,  1'b0, 1'b1, 1'b0, 12'd4095, 12'd4095}
  };

  dir_row_t dir_rows [18] = '{
    '{0, '{KIND_COLOUR, 12'd0, 8'd0, 8'd5, 32'hFFFF_FFFF, 6'd0}, 1'b0, '0},
    '{0, '{KIND_COLOUR, 12'd0, 8'd0, 8'd0, 32'hA5A5_A5A5, 6'd0}, 1'b0, '0},
    '{0, '{KIND_PIXEL, 12'd0, 8'd5, 8'd0, 32'd0, 6'd0}, 1'b0, '0},
    // Single pixel at the far corner of the screen.
    '{0, '{KIND_RENDER, 12'd0, 8'd0, 8'd0, 32'd0, 6'd0}, 1'b1,
      '{13'd4095, 13'd4095, 32'hFFFF_FFFF, 1'b1, 1'b1}},
    // Row beyond the zoomed height and the unused kind give nothing.
    '{0, '{KIND_RENDER, 12'd0, 8'd0, 8'd0, 32'd0, 6'd63}, 1'b0, '0},
    '{0, '{KIND_UNUSED, 12'hFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 6'h3F}, 1'b0, '0},
    '{0, '{KIND_PIXEL, 12'd0, 8'd0, 8'd0, 32'd0, 6'd0}, 1'b0, '0},
    // Index zero in transparent mode is skipped with a zero colour.
    '{0, '{KIND_RENDER, 12'd0, 8'd0, 8'd0, 32'd0, 6'd0}, 1'b1,
      '{13'd4095, 13'd4095, 32'd0, 1'b0, 1'b1}},
    // The same pixel is written when transparency is off.
    '{1, '{KIND_RENDER, 12'd0, 8'd0, 8'd0, 32'd0, 6'd0}, 1'b1,
      '{13'd0, 13'd0, 32'hA5A5_A5A5, 1'b1, 1'b1}},
    '{1, '{KIND_COLOUR, 12'd0, 8'd0, 8'd255, 32'd0, 6'd0}, 1'b0, '0},
    '{1, '{KIND_PIXEL, 12'd4095, 8'd255, 8'd0, 32'd0, 6'd0}, 1'b0, '0},
    '{1, '{KIND_COLOUR, 12'd0, 8'd0, 8'd5, 32'h0000_0001, 6'd0}, 1'b0, '0},
    '{2, '{KIND_RENDER, 12'd0, 8'd0, 8'd0, 32'd0, 6'd0}, 1'b0, '0},
    '{2, '{KIND_RENDER, 12'd0, 8'd0, 8'd0, 32'd0, 6'd63}, 1'b0, '0},
    '{2, '{KIND_RENDER, 12'd0, 8'd0, 8'd0, 32'd0, 6'd31}, 1'b0, '0},
    '{3, '{KIND_RENDER, 12'd0, 8'd0, 8'd0, 32'd0, 6'd1}, 1'b0, '0},
    '{3, '{KIND_RENDER, 12'd0, 8'd0, 8'd0, 32'd0, 6'd0}, 1'b0, '0},
    '{3, '{KIND_RENDER, 12'd0, 8'd0, 8'd0, 32'd0, 6'd2}, 1'b0, '0}
  };

  zoomed_sprite_blitter_core #(
    .SPRITE_SIZE   (SPRITE_SIZE),
    .COLOUR_ENTRIES(COLOUR_ENTRIES),
    .COLOUR_WIDTH  (CVAL_W)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .pixel_address_i (pixel_address_i),
    .pixel_index_i   (pixel_index_i),
    .colour_address_i(colour_address_i),
    .colour_value_i  (colour_value_i),
    .dest_row_i      (dest_row_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .screen_x_o      (screen_x_o),
    .screen_y_o      (screen_y_o),
    .colour_o        (colour_o),
    .write_enable_o  (write_enable_o),
    .last_o          (last_o)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Run guard: a hung block ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL zoomed_sprite_blitter_core");
      $finish;
    end
  end

  // Output side: random back-pressure, plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every output transfer is matched against the oldest predicted pixel.
  always @(posedge clk_i) begin
    pix_t got;
    pix_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{screen_x_o, screen_y_o, colour_o, write_enable_o, last_o};
      if (pixels_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected pixel: x=%0d y=%0d colour=%h we=%b last=%b",
                   got.screen_x, got.screen_y, got.colour, got.write_enable, got.last);
      end else begin
        want = pixels_due.pop_front();
        if (got.screen_x !== want.screen_x || got.screen_y !== want.screen_y ||
            got.colour !== want.colour || got.write_enable !== want.write_enable ||
            got.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("pixel mismatch: expected x=%0d y=%0d colour=%h we=%b last=%b, got x=%0d y=%0d colour=%h we=%b last=%b",
                     want.screen_x, want.screen_y, want.colour, want.write_enable,
                     want.last, got.screen_x, got.screen_y, got.colour,
                     got.write_enable, got.last);
        end
      end
    end
  end

  // Nearest-neighbour source coordinate for destination position d.
  function automatic int nearest_src(input int d, input int zoom, input bit mirror);
    int pos;
    pos = mirror ? (zoom - d) : d;
    return (pos * SPRITE_SIZE) / (zoom + 1);
  endfunction

  // Colour index for a new sprite pixel, with zero made common for transparency.
  function automatic logic [INDEX_W-1:0] pick_index();
    return ($urandom_range(4) == 0) ? '0 : INDEX_W'($urandom_range(255));
  endfunction

  function automatic item_t random_item();
    item_t it;
    it.kind           = 2'($urandom_range(3));
    it.pixel_address  = PIX_ADDR_W'($urandom);
    it.pixel_index    = INDEX_W'($urandom);
    it.colour_address = CADDR_W'($urandom);
    it.colour_value   = $urandom;
    it.dest_row       = ZOOM_W'($urandom);
    return it;
  endfunction

  function automatic cfg_t random_setting();
    cfg_t c;
    c.zoom_x            = ZOOM_W'($urandom);
    c.zoom_y            = ZOOM_W'($urandom);
    c.mirror_horizontal = 1'($urandom);
    c.mirror_vertical   = 1'($urandom);
    c.transparent_mode  = 1'($urandom);
    c.origin_x          = COORD_W'($urandom);
    c.origin_y          = COORD_W'($urandom);
    return c;
  endfunction

  // Predictor: stores loads and expands a render command into its pixels.
  task automatic blit_step(input item_t it);
    int   srow;
    int   addr;
    logic [INDEX_W-1:0] idx;
    bit   we;
    pix_t px;
    case (it.kind)
      KIND_PIXEL: begin
        sprite_mem[it.pixel_address] = it.pixel_index;
        sprite_set[it.pixel_address] = 1'b1;
      end
      KIND_COLOUR: begin
        colour_mem[it.colour_address] = it.colour_value;
        colour_set[it.colour_address] = 1'b1;
      end
      KIND_RENDER: begin
        if (it.dest_row <= blit_cfg.zoom_y) begin
          srow = nearest_src(it.dest_row, blit_cfg.zoom_y, blit_cfg.mirror_vertical);
          for (int c = 0; c <= blit_cfg.zoom_x; c++) begin
            addr = srow * SPRITE_SIZE +
                   nearest_src(c, blit_cfg.zoom_x, blit_cfg.mirror_horizontal);
            idx = sprite_mem[addr];
            we = !(blit_cfg.transparent_mode && idx == '0);
            px.screen_x     = SCREEN_W'(blit_cfg.origin_x) + SCREEN_W'(c);
            px.screen_y     = SCREEN_W'(blit_cfg.origin_y) + SCREEN_W'(it.dest_row);
            px.colour       = we ? colour_mem[idx] : '0;
            px.write_enable = we;
            px.last         = (c == blit_cfg.zoom_x);
            pixels_due.push_back(px);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Offers one item, with random gaps before it, and records it once transferred.
  task automatic offer_item(input item_t it, input bit predicted);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    kind_i           <= it.kind;
    pixel_address_i  <= it.pixel_address;
    pixel_index_i    <= it.pixel_index;
    colour_address_i <= it.colour_address;
    colour_value_i   <= it.colour_value;
    dest_row_i       <= it.dest_row;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (predicted) blit_step(it);
  endtask

  // Loads every sprite pixel and colour entry that a render of this row will read,
  // so that no store entry is ever read before it has been written.
  task automatic prime_row(input logic [ZOOM_W-1:0] drow);
    int    srow;
    int    addr;
    item_t it;
    if (drow > blit_cfg.zoom_y) return;
    srow = nearest_src(drow, blit_cfg.zoom_y, blit_cfg.mirror_vertical);
    for (int c = 0; c <= blit_cfg.zoom_x; c++) begin
      addr = srow * SPRITE_SIZE + nearest_src(c, blit_cfg.zoom_x, blit_cfg.mirror_horizontal);
      if (!sprite_set[addr]) begin
        it               = random_item();
        it.kind          = KIND_PIXEL;
        it.pixel_address = PIX_ADDR_W'(addr);
        it.pixel_index   = pick_index();
        offer_item(it, 1'b1);
      end
    end
    for (int c = 0; c <= blit_cfg.zoom_x; c++) begin
      addr = srow * SPRITE_SIZE + nearest_src(c, blit_cfg.zoom_x, blit_cfg.mirror_horizontal);
      if (!colour_set[sprite_mem[addr]]) begin
        it                = random_item();
        it.kind           = KIND_COLOUR;
        it.colour_address = sprite_mem[addr];
        offer_item(it, 1'b1);
      end
    end
  endtask

  // Waits until every predicted pixel has arrived, then lets the block go quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
  endtask

  // Writes every register; unused upper data bits carry noise that must be dropped.
  task automatic program_config(input cfg_t c);
    write_reg(CFG_ZOOM_X, {6'($urandom), c.zoom_x});
    write_reg(CFG_ZOOM_Y, {6'($urandom), c.zoom_y});
    write_reg(CFG_MIRROR_H, {11'($urandom), c.mirror_horizontal});
    write_reg(CFG_MIRROR_V, {11'($urandom), c.mirror_vertical});
    write_reg(CFG_TRANSPARENT, {11'($urandom), c.transparent_mode});
    write_reg(CFG_ORIGIN_X, c.origin_x);
    write_reg(CFG_ORIGIN_Y, c.origin_y);
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    cfg_we_i <= 1'b0;
    blit_cfg = c;
  endtask

  // Stimulus: directed table, then three idling phases of random traffic.
  initial begin
    item_t it;
    int    sel;
    int    cur_setting;
    cur_setting = -1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].setting != cur_setting) begin
        settle();
        program_config(dir_settings[dir_rows[i].setting]);
        cur_setting = dir_rows[i].setting;
      end
      if (dir_rows[i].it.kind == KIND_RENDER) prime_row(dir_rows[i].it.dest_row);
      offer_item(dir_rows[i].it, !dir_rows[i].typed);
      if (dir_rows[i].typed) pixels_due.push_back(dir_rows[i].px);
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 65 : 0;
      recv_idle_pct = (ph == 0) ? 65 : (ph == 1) ? 22 : 0;
      for (int s = 0; s < 2; s++) begin
        settle();
        program_config(random_setting());
        // Long output stall while rows keep coming, so the input backs up.
        if (ph == 2 && s == 0) hold_req = 1'b1;
        for (int n = 0; n < ITEMS_PER_SET; n++) begin
          it  = random_item();
          sel = $urandom_range(99);
          if (sel < 50) begin
            it.kind = KIND_RENDER;
            if ($urandom_range(4) != 0) it.dest_row = ZOOM_W'($urandom_range(blit_cfg.zoom_y));
            prime_row(it.dest_row);
          end else if (sel < 70) begin
            it.kind        = KIND_PIXEL;
            it.pixel_index = pick_index();
          end else if (sel < 90) begin
            it.kind = KIND_COLOUR;
          end else begin
            it.kind = KIND_UNUSED;
          end
          offer_item(it, 1'b1);
        end
      end
    end

    settle();
    if (mismatch_count == 0 && pixels_due.size() == 0) begin
      $display("PASS zoomed_sprite_blitter_core");
    end else begin
      $display("FAIL zoomed_sprite_blitter_core");
    end
    $finish;
  end

endmodule

@@ zoomed_sprite_blitter_core.f @@
+incdir+rtl
rtl/zsb_pkg.sv
rtl/zsb_div.sv
rtl/zsb_fifo.sv
rtl/zsb_front.sv
rtl/zsb_back.sv
rtl/zoomed_sprite_blitter_core.sv
verif/tb_zoomed_sprite_blitter_core.sv
